>>> src/pattern_bank_associative_match_unit_defines.svh
// assertion macros for the pattern bank match unit
`ifndef PATTERN_BANK_ASSOCIATIVE_MATCH_UNIT_DEFINES_SVH
`define PATTERN_BANK_ASSOCIATIVE_MATCH_UNIT_DEFINES_SVH
`define PBAM_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PBAM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> src/pbam_pkg.sv
// shared types and constants of the pattern bank match unit
package pbam_pkg;
	localparam int LAYERS = 6;
	localparam int BANK_DEPTH = 64;
	localparam int ID_BITS = 9;
	localparam int ELEM_BITS = 16;
	localparam int SLOT_BITS = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int CNT_BITS = 7;
	localparam int TREE_LEAVES = 1 << SLOT_BITS;

	localparam logic [2:0] CMD_CLEAR = 3'd0;
	localparam logic [2:0] CMD_INSERT_ID = 3'd1;
	localparam logic [2:0] CMD_INSERT_NEXT = 3'd2;
	localparam logic [2:0] CMD_READ = 3'd3;
	localparam logic [2:0] CMD_SEARCH = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_DUP = 2'd3;

	typedef logic [ELEM_BITS-1:0] elem_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [8:0] pattern_id;
		logic [15:0] elem_layer0;
		logic [15:0] elem_layer1;
		logic [15:0] elem_layer2;
		logic [15:0] elem_layer3;
		logic [15:0] elem_layer4;
		logic [15:0] elem_layer5;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [8:0] result_id;
		logic [15:0] out_layer0;
		logic [15:0] out_layer1;
		logic [15:0] out_layer2;
		logic [15:0] out_layer3;
		logic [15:0] out_layer4;
		logic [15:0] out_layer5;
		logic [6:0] pattern_count;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic id_hit;
		logic elem_hit;
	} lane_hit_t;
endpackage

>>> src/pbam_lane.sv
// one bank entry: stored id, elements and the compare against a key
module pbam_lane
	import pbam_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic clr,
	input  logic wr,
	input  logic [ID_BITS-1:0] wr_id,
	input  elem_t [LAYERS-1:0] wr_elems,
	input  logic [ID_BITS-1:0] key_id,
	input  elem_t [LAYERS-1:0] key_elems,
	output logic valid,
	output logic [ID_BITS-1:0] id,
	output elem_t [LAYERS-1:0] elems,
	output lane_hit_t hit
);
	logic valid_q;
	logic [ID_BITS-1:0] id_q;
	elem_t [LAYERS-1:0] elems_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clr) begin
			valid_q <= 1'b0;
		end else if (wr) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			id_q <= wr_id;
			elems_q <= wr_elems;
		end
	end

	assign valid = valid_q;
	assign id = id_q;
	assign elems = elems_q;
	assign hit.id_hit = valid_q && (id_q == key_id);
	assign hit.elem_hit = valid_q && (elems_q == key_elems);
endmodule

>>> src/pattern_bank_associative_match_unit.sv
// pattern bank match unit top level: lanes, merge and result sequencer
//  channel | valid      | stall      | payload
//  in      | in_valid   | in_stall   | in_item  (in_item_t)
//  out     | out_valid  | out_stall  | out_item (out_item_t)
// clear and insert: the result is registered in EVAL, after which the unit returns to IDLE
// read: the id hit vector is registered in EVAL and the result is registered in EMIT
// search: hits registered in EVAL, one per cycle from EMIT while out_stall is low, in ascending
// id order through a min-id compare tree; a miss gives one result; in_stall stays high until
// the last; arst_n empties the bank; out_stall holds the result register and the search
module pattern_bank_associative_match_unit
	import pbam_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_item_t in_item,
	output logic out_valid,
	input  logic out_stall,
	output out_item_t out_item
);
	typedef enum logic [1:0] {IDLE, EVAL, EMIT} state_t;
	state_t state_q;
	in_item_t item_q;
	logic [BANK_DEPTH-1:0] id_hit_q, pend_q;
	logic [CNT_BITS-1:0] count_q;
	logic out_valid_q;
	out_item_t out_q;

	elem_t [LAYERS-1:0] key_elems;
	logic [ID_BITS-1:0] key_id;
	logic [BANK_DEPTH-1:0] v_l;
	logic [ID_BITS-1:0] id_l [BANK_DEPTH];
	elem_t [LAYERS-1:0] el_l [BANK_DEPTH];
	lane_hit_t hit_l [BANK_DEPTH];
	logic clr_w, wr_w;
	logic [BANK_DEPTH-1:0] wr_sel;
	logic [ID_BITS-1:0] wr_id;

	always_comb begin
		key_elems = '0;
		key_elems[0] = ELEM_BITS'(item_q.elem_layer0);
		if (LAYERS > 1) key_elems[1 % LAYERS] = ELEM_BITS'(item_q.elem_layer1);
		if (LAYERS > 2) key_elems[2 % LAYERS] = ELEM_BITS'(item_q.elem_layer2);
		if (LAYERS > 3) key_elems[3 % LAYERS] = ELEM_BITS'(item_q.elem_layer3);
		if (LAYERS > 4) key_elems[4 % LAYERS] = ELEM_BITS'(item_q.elem_layer4);
		if (LAYERS > 5) key_elems[5 % LAYERS] = ELEM_BITS'(item_q.elem_layer5);
	end

	assign wr_id = (item_q.cmd == CMD_INSERT_NEXT) ? ID_BITS'(count_q) :
		ID_BITS'(item_q.pattern_id);
	assign key_id = wr_id;

	genvar g;
	generate
		for (g = 0; g < BANK_DEPTH; g++) begin : g_lane
			pbam_lane u_lane (
				.clk(clk), .arst_n(arst_n), .clr(clr_w), .wr(wr_sel[g]),
				.wr_id(wr_id), .wr_elems(key_elems), .key_id(key_id),
				.key_elems(key_elems), .valid(v_l[g]), .id(id_l[g]),
				.elems(el_l[g]), .hit(hit_l[g])
			);
		end
	endgenerate

	// first free slot
	logic [BANK_DEPTH-1:0] free_v, first_free;
	always_comb begin
		free_v = ~v_l;
		first_free = free_v & (~free_v + BANK_DEPTH'(1));
	end

	// minimum-id compare tree over pending hits
	logic t_v [2*TREE_LEAVES];
	logic [ID_BITS-1:0] t_id [2*TREE_LEAVES];
	logic [SLOT_BITS-1:0] t_slot [2*TREE_LEAVES];
	always_comb begin
		t_v[0] = 1'b0;
		t_id[0] = '0;
		t_slot[0] = '0;
		for (int n = 0; n < TREE_LEAVES; n++) begin
			if (n < BANK_DEPTH) begin
				t_v[TREE_LEAVES + n] = pend_q[n];
				t_id[TREE_LEAVES + n] = id_l[n];
			end else begin
				t_v[TREE_LEAVES + n] = 1'b0;
				t_id[TREE_LEAVES + n] = '0;
			end
			t_slot[TREE_LEAVES + n] = SLOT_BITS'(n);
		end
		for (int n = TREE_LEAVES - 1; n >= 1; n--) begin
			if (t_v[2*n] && (!t_v[2*n+1] || t_id[2*n] < t_id[2*n+1])) begin
				t_v[n] = t_v[2*n];
				t_id[n] = t_id[2*n];
				t_slot[n] = t_slot[2*n];
			end else begin
				t_v[n] = t_v[2*n+1];
				t_id[n] = t_id[2*n+1];
				t_slot[n] = t_slot[2*n+1];
			end
		end
	end

	logic [BANK_DEPTH-1:0] min_sel;
	logic [ID_BITS-1:0] min_id;
	logic [SLOT_BITS-1:0] min_slot;
	assign min_id = t_id[1];
	assign min_slot = t_slot[1];
	assign min_sel = t_v[1] ? (BANK_DEPTH'(1) << min_slot) : '0;

	logic [SLOT_BITS-1:0] hit_slot;
	always_comb begin
		hit_slot = '0;
		for (int s = 0; s < BANK_DEPTH; s++)
			if (id_hit_q[s]) hit_slot = SLOT_BITS'(s);
	end

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != IDLE);

	logic [BANK_DEPTH-1:0] id_hit_w, elem_hit_w;
	always_comb begin
		for (int s = 0; s < BANK_DEPTH; s++) begin
			id_hit_w[s] = hit_l[s].id_hit;
			elem_hit_w[s] = hit_l[s].elem_hit;
		end
	end

	logic is_ins;
	assign is_ins = (item_q.cmd == CMD_INSERT_ID) || (item_q.cmd == CMD_INSERT_NEXT);
	assign clr_w = (state_q == EVAL) && out_free && (item_q.cmd == CMD_CLEAR);
	assign wr_w = (state_q == EVAL) && out_free && is_ins && (id_hit_w == '0) &&
		(free_v != '0);
	assign wr_sel = wr_w ? first_free : '0;

	logic [BANK_DEPTH-1:0] pend_next;
	assign pend_next = pend_q & ~min_sel;

	// result built in the cycle it is registered
	out_item_t res_w;
	logic res_go;
	always_comb begin
		res_w = '0;
		res_w.last = 1'b1;
		res_w.pattern_count = count_q;
		case (state_q)
			EVAL: begin
				case (item_q.cmd)
					CMD_CLEAR: res_w.pattern_count = '0;
					CMD_INSERT_ID, CMD_INSERT_NEXT: begin
						res_w.result_id = wr_id;
						if (id_hit_w != '0) res_w.status = ST_DUP;
						else if (free_v == '0) res_w.status = ST_FULL;
						else res_w.pattern_count = count_q + CNT_BITS'(1);
					end
					default: ;
				endcase
			end
			EMIT: begin
				if (item_q.cmd == CMD_READ) begin
					res_w.result_id = ID_BITS'(item_q.pattern_id);
					if (id_hit_q != '0) begin
						res_w.status = ST_OK;
						res_w.out_layer0 = 16'(el_l[hit_slot][0]);
						if (LAYERS > 1) res_w.out_layer1 = 16'(el_l[hit_slot][1 % LAYERS]);
						if (LAYERS > 2) res_w.out_layer2 = 16'(el_l[hit_slot][2 % LAYERS]);
						if (LAYERS > 3) res_w.out_layer3 = 16'(el_l[hit_slot][3 % LAYERS]);
						if (LAYERS > 4) res_w.out_layer4 = 16'(el_l[hit_slot][4 % LAYERS]);
						if (LAYERS > 5) res_w.out_layer5 = 16'(el_l[hit_slot][5 % LAYERS]);
					end else begin
						res_w.status = ST_NOT_FOUND;
					end
				end else if (pend_q == '0) begin
					res_w.status = ST_NOT_FOUND;
				end else begin
					res_w.status = ST_OK;
					res_w.result_id = min_id;
					res_w.last = (pend_next == '0);
				end
			end
			default: ;
		endcase
	end

	assign res_go = out_free && (((state_q == EVAL) &&
		((item_q.cmd == CMD_CLEAR) || is_ins)) || (state_q == EMIT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			out_valid_q <= 1'b0;
			out_q <= '0;
			item_q <= '0;
			id_hit_q <= '0;
			count_q <= '0;
			pend_q <= '0;
		end else begin
			if (res_go) begin
				out_valid_q <= 1'b1;
				out_q <= res_w;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (in_valid) begin
						item_q <= in_item;
						if (in_item.cmd <= CMD_SEARCH) state_q <= EVAL;
					end
				end
				EVAL: begin
					if (out_free) begin
						id_hit_q <= id_hit_w;
						case (item_q.cmd)
							CMD_CLEAR: begin
								count_q <= '0;
								state_q <= IDLE;
							end
							CMD_INSERT_ID, CMD_INSERT_NEXT: begin
								if (wr_w) count_q <= count_q + CNT_BITS'(1);
								state_q <= IDLE;
							end
							CMD_READ: state_q <= EMIT;
							default: begin
								pend_q <= elem_hit_w;
								state_q <= EMIT;
							end
						endcase
					end
				end
				EMIT: begin
					if (out_free) begin
						if (item_q.cmd == CMD_READ || pend_q == '0 || pend_next == '0)
							state_q <= IDLE;
						if (item_q.cmd != CMD_READ) pend_q <= pend_next;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;
endmodule

>>> src/pbam_checker.sv
// port-level checks of the pattern bank match unit, bound to the top level
`include "pattern_bank_associative_match_unit_defines.svh"
module pbam_checker
	import pbam_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  logic out_valid,
	input  logic out_stall,
	input  out_item_t out_item
);
	`PBAM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")
	`PBAM_ASSERT_IMPL(a_count_range, out_valid, out_item.pattern_count <= CNT_BITS'(BANK_DEPTH), "count out of range")
	`PBAM_ASSERT_IMPL(a_layers_zero, out_valid && out_item.status != ST_OK, out_item.out_layer0 == '0 && out_item.out_layer5 == '0, "elements on a non-ok result")
	`PBAM_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall || !out_valid || $past(out_valid), "item took no work")
endmodule

bind pattern_bank_associative_match_unit pbam_checker u_pbam_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);

>>> tb/pattern_bank_associative_match_unit_test.sv
// self-checking testbench for the pattern bank match unit: random commands and a bank model
`timescale 1ns / 1ps

module pattern_bank_associative_match_unit_test;
	import pbam_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;

	pattern_bank_associative_match_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	always #5 clk = ~clk;

	bit bank_valid [BANK_DEPTH];
	logic [ID_BITS-1:0] bank_id [BANK_DEPTH];
	elem_t bank_elem [BANK_DEPTH][LAYERS];
	int bank_count = 0;

	in_item_t pending_items [$];
	out_item_t expected_results [$];
	int errors = 0;
	int idle_wait = 0;
	bit stim_done = 0;
	bit calm = 0;

	task automatic report(input string what);
		$display("mismatch: %s at %0t", what, $time);
		errors++;
	endtask

	task automatic add_expected(input out_item_t r);
		expected_results.insert(expected_results.size(), r);
	endtask

	task automatic queue_item(input in_item_t it);
		pending_items.insert(pending_items.size(), it);
	endtask

	function automatic out_item_t make_result(logic [1:0] st, logic [8:0] id, bit last);
		out_item_t r;
		r = '0;
		r.status = st;
		r.result_id = id;
		r.pattern_count = bank_count[6:0];
		r.last = last;
		return r;
	endfunction

	function automatic int find_slot(logic [8:0] id);
		for (int s = 0; s < BANK_DEPTH; s++)
			if (bank_valid[s] && bank_id[s] == id)
				return s;
		return -1;
	endfunction

	function automatic logic [1:0] bank_insert(logic [8:0] id, elem_t e [LAYERS]);
		if (find_slot(id) >= 0)
			return ST_DUP;
		for (int s = 0; s < BANK_DEPTH; s++)
			if (!bank_valid[s]) begin
				bank_valid[s] = 1;
				bank_id[s] = id;
				for (int l = 0; l < LAYERS; l++)
					bank_elem[s][l] = e[l];
				bank_count++;
				return ST_OK;
			end
		return ST_FULL;
	endfunction

	task automatic predict_bank(input in_item_t it);
		elem_t e [LAYERS];
		logic [8:0] id;
		logic [1:0] st;
		out_item_t r;
		int s;
		bit hits [512];
		int n;
		e[0] = it.elem_layer0; e[1] = it.elem_layer1; e[2] = it.elem_layer2;
		e[3] = it.elem_layer3; e[4] = it.elem_layer4; e[5] = it.elem_layer5;
		case (it.cmd)
			CMD_CLEAR: begin
				for (int k = 0; k < BANK_DEPTH; k++)
					bank_valid[k] = 0;
				bank_count = 0;
				add_expected(make_result(ST_OK, '0, 1));
			end
			CMD_INSERT_ID, CMD_INSERT_NEXT: begin
				id = (it.cmd == CMD_INSERT_ID) ? it.pattern_id : bank_count[8:0];
				st = bank_insert(id, e);
				add_expected(make_result(st, id, 1));
			end
			CMD_READ: begin
				s = find_slot(it.pattern_id);
				if (s >= 0) begin
					r = make_result(ST_OK, it.pattern_id, 1);
					r.out_layer0 = bank_elem[s][0]; r.out_layer1 = bank_elem[s][1];
					r.out_layer2 = bank_elem[s][2]; r.out_layer3 = bank_elem[s][3];
					r.out_layer4 = bank_elem[s][4]; r.out_layer5 = bank_elem[s][5];
					add_expected(r);
				end else
					add_expected(make_result(ST_NOT_FOUND, it.pattern_id, 1));
			end
			CMD_SEARCH: begin
				n = 0;
				for (int k = 0; k < BANK_DEPTH; k++)
					if (bank_valid[k] && bank_elem[k] == e) begin
						hits[bank_id[k]] = 1;
						n++;
					end
				if (n == 0)
					add_expected(make_result(ST_NOT_FOUND, '0, 1));
				else
					for (int k = 0; k < 512; k++)
						if (hits[k]) begin
							n--;
							add_expected(make_result(ST_OK, k[8:0], n == 0));
						end
			end
			default: ;
		endcase
	endtask

	function automatic bit maybe_idle();
		return !calm && ($urandom_range(99) < 13);
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_bank(in_item);
				void'(pending_items.pop_front());
			end
			if (in_valid && in_stall)
				;
			else if (pending_items.size() > (in_valid && !in_stall ? 0 : 0) && !maybe_idle()) begin
				in_valid <= 1'b1;
				in_item <= pending_items[0];
			end else
				in_valid <= 1'b0;
			out_stall <= maybe_idle();
		end
	end

	// monitor
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0)
				report("result with none expected");
			else begin
				want = expected_results.pop_front();
				if (out_item.status !== want.status) report("status");
				if (out_item.result_id !== want.result_id) report("result_id");
				if (out_item.out_layer0 !== want.out_layer0) report("out_layer0");
				if (out_item.out_layer1 !== want.out_layer1) report("out_layer1");
				if (out_item.out_layer2 !== want.out_layer2) report("out_layer2");
				if (out_item.out_layer3 !== want.out_layer3) report("out_layer3");
				if (out_item.out_layer4 !== want.out_layer4) report("out_layer4");
				if (out_item.out_layer5 !== want.out_layer5) report("out_layer5");
				if (out_item.pattern_count !== want.pattern_count) report("pattern_count");
				if (out_item.last !== want.last) report("last");
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_wait <= 0;
		else if (arst_n)
			idle_wait <= idle_wait + 1;
		if (idle_wait > 5000) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic in_item_t make_item(logic [2:0] cmd, logic [8:0] id, logic [15:0] v);
		in_item_t it;
		it.cmd = cmd;
		it.pattern_id = id;
		it.elem_layer0 = v; it.elem_layer1 = v; it.elem_layer2 = v;
		it.elem_layer3 = v; it.elem_layer4 = v; it.elem_layer5 = v;
		return it;
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		logic [15:0] pool [4] = '{16'h0000, 16'hffff, 16'h1234, 16'h00a5};
		int r;
		it.pattern_id = 9'($urandom);
		it.elem_layer0 = 16'($urandom); it.elem_layer1 = 16'($urandom);
		it.elem_layer2 = 16'($urandom); it.elem_layer3 = 16'($urandom);
		it.elem_layer4 = 16'($urandom); it.elem_layer5 = 16'($urandom);
		r = $urandom_range(99);
		if (r < 5) it.cmd = CMD_CLEAR;
		else if (r < 35) it.cmd = CMD_INSERT_ID;
		else if (r < 50) it.cmd = CMD_INSERT_NEXT;
		else if (r < 70) it.cmd = CMD_READ;
		else if (r < 97) it.cmd = CMD_SEARCH;
		else it.cmd = 3'($urandom_range(7, 5));
		// narrow ids and elements so reads and searches hit
		if ($urandom_range(3) != 0) it.pattern_id = 9'($urandom_range(79));
		if ($urandom_range(3) != 0) begin
			it.elem_layer0 = pool[$urandom_range(3)];
			it.elem_layer1 = pool[$urandom_range(3)];
			it.elem_layer2 = pool[$urandom_range(1)];
			it.elem_layer3 = pool[0];
			it.elem_layer4 = pool[$urandom_range(1)];
			it.elem_layer5 = pool[0];
		end
		return it;
	endfunction

	initial begin
		queue_item(make_item(CMD_SEARCH, 9'd0, 16'h0000));
		queue_item(make_item(CMD_READ, 9'd511, 16'h0000));
		queue_item(make_item(CMD_INSERT_ID, 9'd511, 16'hffff));
		queue_item(make_item(CMD_INSERT_ID, 9'd511, 16'h0000));
		queue_item(make_item(CMD_INSERT_ID, 9'd0, 16'h0000));
		queue_item(make_item(CMD_INSERT_NEXT, 9'd0, 16'hffff));
		queue_item(make_item(CMD_INSERT_NEXT, 9'd0, 16'hffff));
		queue_item(make_item(CMD_READ, 9'd511, 16'h0000));
		queue_item(make_item(CMD_SEARCH, 9'd0, 16'hffff));
		queue_item(make_item(3'd5, 9'd0, 16'h0000));
		queue_item(make_item(3'd7, 9'd1, 16'hffff));
		queue_item(make_item(CMD_CLEAR, 9'd0, 16'h0000));
		queue_item(make_item(CMD_READ, 9'd0, 16'h0000));
		for (int k = 0; k < BANK_DEPTH; k++)
			queue_item(make_item(CMD_INSERT_ID, 9'(k * 7), 16'h0001));
		queue_item(make_item(CMD_INSERT_ID, 9'd500, 16'h0001));
		queue_item(make_item(CMD_INSERT_ID, 9'd7, 16'h0001));
		queue_item(make_item(CMD_INSERT_NEXT, 9'd0, 16'h0001));
		queue_item(make_item(CMD_SEARCH, 9'd0, 16'h0001));
		queue_item(make_item(CMD_CLEAR, 9'd0, 16'h0000));
		for (int k = 0; k < 340; k++)
			queue_item(random_item());
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (200) @(posedge clk);
		calm = 1;
		repeat (400) @(posedge clk);
		calm = 0;
		wait (pending_items.size() == 0 && !in_valid);
		wait (expected_results.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

>>> files.f
+incdir+src
src/pbam_pkg.sv
src/pbam_lane.sv
src/pattern_bank_associative_match_unit.sv
src/pbam_checker.sv
tb/pattern_bank_associative_match_unit_test.sv
